[hw/rtl/fid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer package
// Shared constants, register codes and channel status type for the
// four-input integrating debouncer.
// ----------------------------------------------------------------------------
package fid_pkg;

  localparam int CountMaxDefault = 255;
  localparam int ThrWidth        = 8;
  localparam int CfgIdxWidth     = 1;
  localparam int RiseThrReset    = 170;
  localparam int FallThrReset    = 85;
  localparam int ShdnCountReset  = 100;
  localparam int NumPins         = 4;
  localparam int NumFlags        = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegRiseThr = 1'b0,
    RegFallThr = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdRead   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic level_d;
    logic rise;
    logic fall;
  } chan_st_t;

endpackage
`default_nettype wire

[hw/rtl/fid_channel.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer channel
// Saturating integrator with a hysteresis comparator for one active-low pin.
// ----------------------------------------------------------------------------
module fid_channel #(
  parameter int CountMax   = fid_pkg::CountMaxDefault,
  parameter int ResetCount = fid_pkg::CountMaxDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         pin_i,
  input  wire logic [fid_pkg::ThrWidth-1:0] rise_thr_i,
  input  wire logic [fid_pkg::ThrWidth-1:0] fall_thr_i,
  output fid_pkg::chan_st_t                 st_o
);

  localparam int CntW = $clog2(CountMax + 1);
  localparam int CmpW = (CntW > fid_pkg::ThrWidth) ? CntW : fid_pkg::ThrWidth;

  logic [CntW-1:0] count_q, count_d;
  logic            filt_q;
  logic [CmpW-1:0] count_ext;
  logic            above_rise, above_fall, level_next;

  always_comb begin
    count_d = count_q;
    if (!pin_i) begin
      if (count_q < CntW'(CountMax)) begin
        count_d = count_q + 1'b1;
      end
    end else if (count_q != '0) begin
      count_d = count_q - 1'b1;
    end
  end

  assign count_ext  = CmpW'(count_d);
  assign above_rise = count_ext > CmpW'(rise_thr_i);
  assign above_fall = count_ext > CmpW'(fall_thr_i);
  assign level_next = filt_q ? above_fall : above_rise;

  assign st_o.level_d = level_next;
  assign st_o.rise    = !filt_q && level_next;
  assign st_o.fall    = filt_q && !level_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(ResetCount);
      filt_q  <= 1'b1;
    end else if (en_i) begin
      count_q <= count_d;
      filt_q  <= level_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/four_input_integrating_debouncer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-input integrating debouncer
// Qualifies four active-low pins with saturating counters and hysteresis,
// keeps sticky edge flags and returns a status word for every request.
// ----------------------------------------------------------------------------
//   Channel  Signals                          Direction
//   in       in_valid_i / in_ready_o          request: command and four pins
//   out      out_valid_o / out_ready_i        status: four levels, three flags
//   cfg      cfg_we_i, cfg_idx_i, cfg_wdata_i threshold register writes
//
// Each request is taken into an input register and resolved from there into
// the result register, so one request is accepted per cycle while the result
// register does not stall. The result register stalls on out_ready_i and the
// input register fills behind it. Reset sets the counters, levels and
// thresholds to their start values and empties both registers.
// ----------------------------------------------------------------------------
module four_input_integrating_debouncer #(
  parameter int CountMax = fid_pkg::CountMaxDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic                            command_i,
  input  wire logic                            pin_dci_i,
  input  wire logic                            pin_rat_i,
  input  wire logic                            pin_wp_i,
  input  wire logic                            pin_shdn_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic                            dci_level_o,
  output      logic                            rat_level_o,
  output      logic                            wp_level_o,
  output      logic                            shdn_level_o,
  output      logic                            dci_rise_seen_o,
  output      logic                            rat_rise_seen_o,
  output      logic                            shdn_fall_seen_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fid_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [fid_pkg::ThrWidth-1:0]    cfg_wdata_i
);

  localparam int ShdnReset =
    (CountMax < fid_pkg::ShdnCountReset) ? CountMax : fid_pkg::ShdnCountReset;

  logic [fid_pkg::ThrWidth-1:0] rise_thr_q, fall_thr_q;

  logic                        in_vld_q;
  fid_pkg::cmd_e               cmd_q;
  logic [fid_pkg::NumPins-1:0] pins_q;

  logic                         out_vld_q;
  logic [fid_pkg::NumPins-1:0]  out_lvl_q, out_lvl_d;
  logic [fid_pkg::NumFlags-1:0] out_flg_q, out_flg_d;

  logic [fid_pkg::NumPins-1:0]  reported_q, reported_d;
  logic [fid_pkg::NumFlags-1:0] sticky_q, sticky_d;

  logic step, sample;
  fid_pkg::chan_st_t st_dci, st_rat, st_wp, st_shdn;
  logic [fid_pkg::NumPins-1:0]  lvl_new;
  logic [fid_pkg::NumFlags-1:0] flg_new;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign sample     = step && (cmd_q == fid_pkg::CmdSample);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_thr_q <= fid_pkg::ThrWidth'(fid_pkg::RiseThrReset);
      fall_thr_q <= fid_pkg::ThrWidth'(fid_pkg::FallThrReset);
    end else if (cfg_we_i) begin
      unique case (fid_pkg::cfg_reg_e'(cfg_idx_i))
        fid_pkg::RegRiseThr: rise_thr_q <= cfg_wdata_i;
        fid_pkg::RegFallThr: fall_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q  <= fid_pkg::cmd_e'(command_i);
      pins_q <= {pin_shdn_i, pin_wp_i, pin_rat_i, pin_dci_i};
    end
  end

  fid_channel #(.CountMax(CountMax), .ResetCount(CountMax)) u_dci (
    .clk_i, .rst_ni, .en_i(sample), .pin_i(pins_q[0]),
    .rise_thr_i(rise_thr_q), .fall_thr_i(fall_thr_q), .st_o(st_dci)
  );

  fid_channel #(.CountMax(CountMax), .ResetCount(CountMax)) u_rat (
    .clk_i, .rst_ni, .en_i(sample), .pin_i(pins_q[1]),
    .rise_thr_i(rise_thr_q), .fall_thr_i(fall_thr_q), .st_o(st_rat)
  );

  fid_channel #(.CountMax(CountMax), .ResetCount(CountMax)) u_wp (
    .clk_i, .rst_ni, .en_i(sample), .pin_i(pins_q[2]),
    .rise_thr_i(rise_thr_q), .fall_thr_i(fall_thr_q), .st_o(st_wp)
  );

  fid_channel #(.CountMax(CountMax), .ResetCount(ShdnReset)) u_shdn (
    .clk_i, .rst_ni, .en_i(sample), .pin_i(pins_q[3]),
    .rise_thr_i(rise_thr_q), .fall_thr_i(fall_thr_q), .st_o(st_shdn)
  );

  assign lvl_new = {st_shdn.level_d, st_wp.level_d, st_rat.level_d, st_dci.level_d};
  assign flg_new = sticky_q | {st_shdn.fall, st_rat.rise, st_dci.rise};

  always_comb begin
    reported_d = reported_q;
    sticky_d   = sticky_q;
    out_lvl_d  = reported_q;
    out_flg_d  = sticky_q;
    case (cmd_q)
      fid_pkg::CmdSample: begin
        reported_d = lvl_new;
        sticky_d   = flg_new;
        out_lvl_d  = lvl_new;
        out_flg_d  = flg_new;
      end
      fid_pkg::CmdRead: begin
        sticky_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reported_q <= '0;
      sticky_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (step) begin
        reported_q <= reported_d;
        sticky_q   <= sticky_d;
        out_vld_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_lvl_q <= out_lvl_d;
      out_flg_q <= out_flg_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign dci_level_o      = out_lvl_q[0];
  assign rat_level_o      = out_lvl_q[1];
  assign wp_level_o       = out_lvl_q[2];
  assign shdn_level_o     = out_lvl_q[3];
  assign dci_rise_seen_o  = out_flg_q[0];
  assign rat_rise_seen_o  = out_flg_q[1];
  assign shdn_fall_seen_o = out_flg_q[2];

endmodule
`default_nettype wire
